// File: hdl/spd_pkg.sv
// ----------------------------------------------------------------------------
// spd_pkg
// Shared constants and types for the shortest-path distance engine.
// ----------------------------------------------------------------------------
package spd_pkg;

	// defaults for the top-level parameters
	localparam int SPD_NODES       = 16;
	localparam int SPD_WEIGHT_BITS = 8;

	// fixed field widths of the stream words
	localparam int SPD_NODE_W      = 4;
	localparam int SPD_WEIGHT_W    = 8;
	localparam int SPD_DIST_W      = 12;
	localparam int SPD_IN_DATA_W   = 16;
	localparam int SPD_OUT_DATA_W  = 16;
	localparam int SPD_OUT_USER_W  = 2;

	localparam logic [SPD_DIST_W-1:0] SPD_DIST_MAX = 12'd4095;

	// entries of the queue between front and back
	localparam int SPD_QUEUE_DEPTH = 2;

	localparam logic OP_LOAD = 1'b0;

	// what the back end does with a queued word
	typedef enum logic [1:0] {
		KIND_LOAD  = 2'd0,   // write one matrix entry
		KIND_SKIP  = 2'd1,   // load with a node out of range
		KIND_QUERY = 2'd2,   // run the search
		KIND_BAD   = 2'd3    // query with a node out of range
	} kind_t;

	typedef struct packed {
		kind_t                   kind;
		logic [SPD_NODE_W-1:0]   from_node;
		logic [SPD_NODE_W-1:0]   to_node;
		logic [SPD_WEIGHT_W-1:0] weight;
	} item_t;

endpackage

// File: hdl/shortest_path_distance.sv
// ----------------------------------------------------------------------------
// shortest_path_distance
// Single-source shortest-path engine over a dense weighted adjacency matrix.
// ----------------------------------------------------------------------------
// channel  dir  tdata (low bit up)                    tuser
// s_       in   from_node[3:0] to_node[7:4] weight    operation (0 load, 1 query)
// m_       out  distance[11:0], zero pad to 16 bits   reachable[0] saturated[1]
//
// A load word is written to the matrix at the edge that takes it from the queue.
// A query settles one node per round; in each round the PASS state reads the
// edge row of that node through the single read port of the edge matrix RAM,
// followed by DRAIN and END. After reset a clearing pass zeroes the matrix
// while s_tready stays low. A two-word queue lets the input keep accepting
// while the back end searches or the result waits.
// ----------------------------------------------------------------------------
module shortest_path_distance #(
	parameter int NODES       = spd_pkg::SPD_NODES,
	parameter int WEIGHT_BITS = spd_pkg::SPD_WEIGHT_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [spd_pkg::SPD_IN_DATA_W-1:0]  s_tdata,   // from_node, to_node, weight
	input  logic                               s_tuser,   // operation
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [spd_pkg::SPD_OUT_DATA_W-1:0] m_tdata,   // distance
	output logic [spd_pkg::SPD_OUT_USER_W-1:0] m_tuser    // reachable, saturated
);

	import spd_pkg::*;

	logic  q_valid;
	logic  q_ready;
	item_t q_item;
	logic  clearing;

	spd_front #(
		.NODES (NODES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.clearing (clearing),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_item   (q_item)
	);

	spd_engine #(
		.NODES       (NODES),
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_item   (q_item),
		.clearing (clearing),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

// File: hdl/spd_ram.sv
// ----------------------------------------------------------------------------
// spd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module spd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: hdl/spd_front.sv
// ----------------------------------------------------------------------------
// spd_front
// Accepts input words, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module spd_front #(
	parameter int NODES = spd_pkg::SPD_NODES
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [spd_pkg::SPD_IN_DATA_W-1:0] s_tdata,  // from_node, to_node, weight
	input  logic                             s_tuser,  // operation
	input  logic                             clearing,
	output logic                             q_valid,
	input  logic                             q_ready,
	output spd_pkg::item_t                   q_item
);

	import spd_pkg::*;

	localparam int QD = SPD_QUEUE_DEPTH;
	localparam int PW = (QD > 1) ? $clog2(QD) : 1;

	item_t            buf_q [QD];
	logic [PW-1:0]    wr_q;
	logic [PW-1:0]    rd_q;
	logic [PW:0]      cnt_q;
	item_t            in_item;
	logic             in_range;
	logic             push;
	logic             pop;

	always_comb begin
		in_item.from_node = s_tdata[3:0];
		in_item.to_node   = s_tdata[7:4];
		in_item.weight    = s_tdata[15:8];
		in_range = (32'(in_item.from_node) < NODES) && (32'(in_item.to_node) < NODES);
		if (s_tuser == OP_LOAD) begin
			in_item.kind = in_range ? KIND_LOAD : KIND_SKIP;
		end else begin
			in_item.kind = in_range ? KIND_QUERY : KIND_BAD;
		end
	end

	assign s_tready = (cnt_q != (PW+1)'(QD)) && !clearing;
	assign q_valid  = (cnt_q != '0);
	assign q_item   = buf_q[rd_q];
	assign push     = s_tvalid && s_tready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(QD-1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(QD-1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: hdl/spd_engine.sv
// ----------------------------------------------------------------------------
// spd_engine
// Back end: edge matrix, search sequencer and result register.
// ----------------------------------------------------------------------------
module spd_engine #(
	parameter int NODES       = spd_pkg::SPD_NODES,
	parameter int WEIGHT_BITS = spd_pkg::SPD_WEIGHT_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               q_valid,
	output logic                               q_ready,
	input  spd_pkg::item_t                     q_item,
	output logic                               clearing,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [spd_pkg::SPD_OUT_DATA_W-1:0] m_tdata,  // distance
	output logic [spd_pkg::SPD_OUT_USER_W-1:0] m_tuser   // reachable, saturated
);

	import spd_pkg::*;

	localparam int NB   = $clog2(NODES);
	localparam int AW   = $clog2(NODES * NODES);
	localparam int WB   = WEIGHT_BITS;
	localparam int SUMW = ((WB > SPD_DIST_W) ? WB : SPD_DIST_W) + 1;

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_START = 3'd2;
	localparam logic [2:0] ST_PASS  = 3'd3;
	localparam logic [2:0] ST_DRAIN = 3'd4;
	localparam logic [2:0] ST_END   = 3'd5;

	logic [2:0]            state_q;
	logic [AW-1:0]         clr_q;
	logic [NB-1:0]         u_q;
	logic [NB-1:0]         dst_q;
	logic [SPD_DIST_W-1:0] du_q;
	logic                  cu_q;
	logic [NB-1:0]         v_q;
	logic                  pv_s1;
	logic [NB-1:0]         v_s1;
	logic [NODES-1:0]      valid_q;
	logic [NODES-1:0]      settled_q;
	logic [NODES-1:0]      clip_q;
	logic                  min_found_q;
	logic [NB-1:0]         min_v_q;
	logic [SPD_DIST_W-1:0] min_d_q;
	logic                  min_c_q;
	logic                  out_valid_q;
	logic [SPD_DIST_W-1:0] out_dist_q;
	logic                  out_reach_q;
	logic                  out_sat_q;

	// memory ports
	logic                  e_we;
	logic [AW-1:0]         e_waddr;
	logic [WB-1:0]         e_wdata;
	logic [AW-1:0]         e_raddr;
	logic [WB-1:0]         e_rdata;
	logic [SPD_DIST_W-1:0] d_rdata;

	// relax stage
	logic [SUMW-1:0]       sum;
	logic [SPD_DIST_W-1:0] nd;
	logic                  nc;
	logic                  vis_valid;
	logic                  vis_set;
	logic                  vis_clip;
	logic                  relax;
	logic [SPD_DIST_W-1:0] new_d;
	logic                  new_valid;
	logic                  new_c;
	logic                  take;

	logic                  pop;
	logic                  pop_ok;
	logic                  res_set;

	assign clearing = (state_q == ST_CLEAR);

	// loads never touch the result register, queries need it empty
	assign pop_ok  = (q_item.kind == KIND_LOAD) || (q_item.kind == KIND_SKIP) || !out_valid_q;
	assign q_ready = (state_q == ST_IDLE) && pop_ok;
	assign pop     = q_valid && q_ready;

	// a result word is produced this cycle
	assign res_set = (pop && (q_item.kind == KIND_BAD)) ||
		((state_q == ST_START) && (u_q == dst_q)) ||
		((state_q == ST_END) && !min_found_q);

	always_comb begin
		e_we    = 1'b0;
		e_waddr = clr_q;
		e_wdata = '0;
		if (state_q == ST_CLEAR) begin
			e_we = 1'b1;
		end else if (pop && (q_item.kind == KIND_LOAD)) begin
			e_we    = 1'b1;
			e_waddr = AW'(32'(q_item.from_node) * NODES + 32'(q_item.to_node));
			e_wdata = WB'(q_item.weight);
		end
	end

	assign e_raddr = AW'(32'(u_q) * NODES + 32'(v_q));

	spd_ram #(
		.WIDTH (WB),
		.DEPTH (NODES * NODES)
	) u_edge_ram (
		.clk   (clk),
		.we    (e_we),
		.waddr (e_waddr),
		.wdata (e_wdata),
		.raddr (e_raddr),
		.rdata (e_rdata)
	);

	spd_ram #(
		.WIDTH (SPD_DIST_W),
		.DEPTH (NODES)
	) u_dist_ram (
		.clk   (clk),
		.we    (relax),
		.waddr (v_s1),
		.wdata (nd),
		.raddr (v_q),
		.rdata (d_rdata)
	);

	// relax one neighbor and track the next node to settle
	always_comb begin
		vis_valid = valid_q[v_s1];
		vis_set   = settled_q[v_s1];
		vis_clip  = clip_q[v_s1];
		sum       = SUMW'(du_q) + SUMW'(e_rdata);
		if (sum > SUMW'(SPD_DIST_MAX)) begin
			nd = SPD_DIST_MAX;
			nc = 1'b1;
		end else begin
			nd = sum[SPD_DIST_W-1:0];
			nc = cu_q;
		end
		relax = pv_s1 && (e_rdata != '0) && !vis_set &&
			(!vis_valid || (nd < d_rdata) || ((nd == d_rdata) && vis_clip && !nc));
		new_d     = relax ? nd : d_rdata;
		new_valid = vis_valid || relax;
		new_c     = relax ? nc : vis_clip;
		// strict compare in index order keeps the lowest index on ties
		take = pv_s1 && new_valid && !vis_set && (!min_found_q || (new_d < min_d_q));
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			u_q   <= NB'(q_item.from_node);
			dst_q <= NB'(q_item.to_node);
			du_q  <= '0;
			cu_q  <= 1'b0;
		end else if ((state_q == ST_END) && min_found_q) begin
			u_q  <= min_v_q;
			du_q <= min_d_q;
			cu_q <= min_c_q;
		end
		v_s1 <= v_q;
		if (take) begin
			min_v_q <= v_s1;
			min_d_q <= new_d;
			min_c_q <= new_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			v_q         <= '0;
			pv_s1       <= 1'b0;
			valid_q     <= '0;
			settled_q   <= '0;
			clip_q      <= '0;
			min_found_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_dist_q  <= '0;
			out_reach_q <= 1'b0;
			out_sat_q   <= 1'b0;
		end else begin
			pv_s1 <= (state_q == ST_PASS);
			if (res_set) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (pv_s1) begin
				valid_q[v_s1] <= new_valid;
				clip_q[v_s1]  <= new_c;
			end
			if (take) begin
				min_found_q <= 1'b1;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(NODES * NODES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (pop) begin
						if (q_item.kind == KIND_BAD) begin
							out_dist_q  <= '0;
							out_reach_q <= 1'b0;
							out_sat_q   <= 1'b0;
						end else if (q_item.kind == KIND_QUERY) begin
							valid_q   <= NODES'(1) << NB'(q_item.from_node);
							settled_q <= '0;
							clip_q    <= '0;
							state_q   <= ST_START;
						end
					end
				end
				ST_START: begin
					settled_q[u_q] <= 1'b1;
					if (u_q == dst_q) begin
						out_dist_q  <= du_q;
						out_reach_q <= 1'b1;
						out_sat_q   <= cu_q;
						state_q     <= ST_IDLE;
					end else begin
						v_q         <= '0;
						min_found_q <= 1'b0;
						state_q     <= ST_PASS;
					end
				end
				ST_PASS: begin
					v_q <= v_q + 1'b1;
					if (v_q == NB'(NODES - 1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_END;
				end
				ST_END: begin
					if (min_found_q) begin
						state_q <= ST_START;
					end else begin
						// nothing left to settle: destination not reached
						out_dist_q  <= '0;
						out_reach_q <= 1'b0;
						out_sat_q   <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(SPD_OUT_DATA_W - SPD_DIST_W){1'b0}}, out_dist_q};
	assign m_tuser  = {out_sat_q, out_reach_q};

endmodule

// File: tb/sv/tb_shortest_path_distance.sv
// ----------------------------------------------------------------------------
// tb_shortest_path_distance
// Self-checking bench for the shortest-path distance engine. Edge loads and
// distance queries go in through the input stream. A local Dijkstra search
// over a shadow copy of the matrix predicts every query answer. Answers are
// checked in order across phases where neither, one or both stream sides idle or stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_shortest_path_distance;

	import spd_pkg::*;

	localparam int   NODES           = SPD_NODES;
	localparam logic OP_QUERY        = ~OP_LOAD;
	localparam logic [SPD_WEIGHT_W-1:0] WEIGHT_MASK =
		SPD_WEIGHT_W'((1 << SPD_WEIGHT_BITS) - 1);
	localparam int   WORDS_PER_PHASE = 450;
	localparam int   DRAIN_CYCLES    = 400;
	// covers the clearing pass plus two queued full searches, with margin
	localparam int   QUIET_LIMIT     = 4000;
	localparam int   SEND_IDLE_PCT [4] = '{0, 66, 0, 24};
	localparam int   RECV_STALL_PCT[4] = '{0, 0, 66, 24};

	typedef struct {
		logic                    operation;
		logic [SPD_NODE_W-1:0]   from_node;
		logic [SPD_NODE_W-1:0]   to_node;
		logic [SPD_WEIGHT_W-1:0] weight;
	} spd_word_t;

	typedef struct {
		logic [SPD_DIST_W-1:0] distance;
		logic                  reachable;
		logic                  saturated;
	} spd_answer_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                      s_tvalid = 1'b0;
	logic                      s_tready;
	logic [SPD_IN_DATA_W-1:0]  s_tdata  = '0;
	logic                      s_tuser  = 1'b0;
	logic                      m_tvalid;
	logic                      m_tready = 1'b0;
	logic [SPD_OUT_DATA_W-1:0] m_tdata;
	logic [SPD_OUT_USER_W-1:0] m_tuser;

	spd_word_t   pending_words[$];
	spd_answer_t expected_answers[$];
	spd_answer_t head_answer;

	// shadow of the edge matrix
	logic [SPD_WEIGHT_W-1:0] adj_weight [NODES][NODES] = '{default: '0};

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int error_count    = 0;
	int quiet_cycles   = 0;
	int load_count     = 0;
	int query_count    = 0;
	int unreach_count  = 0;

	shortest_path_distance dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #5 clk = ~clk;

	function automatic spd_answer_t shortest_distance(int src, int dst);
		logic [SPD_DIST_W-1:0] tent_dist [NODES];
		bit          settled [NODES];
		bit          known   [NODES];
		bit          clipped [NODES];
		int          u;
		int          nd;
		bit          nc;
		spd_answer_t ans;
		for (int v = 0; v < NODES; v++) begin
			tent_dist[v] = '0;
			settled[v]   = 1'b0;
			known[v]     = 1'b0;
			clipped[v]   = 1'b0;
		end
		known[src] = 1'b1;
		for (int round = 0; round < NODES; round++) begin
			// lowest index wins a tie
			u = NODES;
			for (int v = 0; v < NODES; v++) begin
				if (known[v] && !settled[v]) begin
					if (u == NODES) u = v;
					else if (tent_dist[v] < tent_dist[u]) u = v;
				end
			end
			if (u == NODES) break;
			settled[u] = 1'b1;
			if (u == dst) break;
			for (int v = 0; v < NODES; v++) begin
				if (adj_weight[u][v] != '0 && !settled[v]) begin
					nd = int'(tent_dist[u]) + int'(adj_weight[u][v]);
					nc = clipped[u];
					if (nd > int'(SPD_DIST_MAX)) begin
						nd = int'(SPD_DIST_MAX);
						nc = 1'b1;
					end
					// an unclipped path displaces a clipped one of equal length
					if (!known[v] || nd < int'(tent_dist[v]) ||
							(nd == int'(tent_dist[v]) && clipped[v] && !nc)) begin
						tent_dist[v] = nd[SPD_DIST_W-1:0];
						clipped[v]   = nc;
						known[v]     = 1'b1;
					end
				end
			end
		end
		ans.distance  = known[dst] ? tent_dist[dst] : '0;
		ans.reachable = known[dst];
		ans.saturated = known[dst] ? clipped[dst] : 1'b0;
		return ans;
	endfunction

	function automatic void apply_word(spd_word_t w);
		spd_answer_t ans;
		if (w.operation == OP_LOAD) begin
			load_count++;
			if (int'(w.from_node) < NODES && int'(w.to_node) < NODES)
				adj_weight[w.from_node][w.to_node] = w.weight & WEIGHT_MASK;
		end else begin
			query_count++;
			if (int'(w.from_node) < NODES && int'(w.to_node) < NODES)
				ans = shortest_distance(int'(w.from_node), int'(w.to_node));
			else
				ans = '{distance: '0, reachable: 1'b0, saturated: 1'b0};
			if (!ans.reachable) unreach_count++;
			expected_answers.push_back(ans);
		end
	endfunction

	function automatic void push_load(int from_n, int to_n, int w);
		pending_words.push_back('{OP_LOAD, from_n[SPD_NODE_W-1:0], to_n[SPD_NODE_W-1:0],
			w[SPD_WEIGHT_W-1:0]});
	endfunction

	function automatic void push_query(int from_n, int to_n);
		pending_words.push_back('{OP_QUERY, from_n[SPD_NODE_W-1:0], to_n[SPD_NODE_W-1:0],
			SPD_WEIGHT_W'($urandom)});
	endfunction

	// input driver: valid holds until the word is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				apply_word(pending_words.pop_front());
			if (!s_tvalid || s_tready) begin
				if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata  <= {pending_words[0].weight, pending_words[0].to_node,
						pending_words[0].from_node};
					s_tuser  <= pending_words[0].operation;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_answers.size() == 0) begin
					$error("result word with no query pending: tdata=%h tuser=%b",
						m_tdata, m_tuser);
					error_count++;
				end else begin
					head_answer = expected_answers.pop_front();
					if (m_tdata[SPD_DIST_W-1:0] !== head_answer.distance) begin
						$error("distance: expected %0d, got %0d",
							head_answer.distance, m_tdata[SPD_DIST_W-1:0]);
						error_count++;
					end
					if (m_tuser[0] !== head_answer.reachable) begin
						$error("reachable: expected %b, got %b",
							head_answer.reachable, m_tuser[0]);
						error_count++;
					end
					if (m_tuser[1] !== head_answer.saturated) begin
						$error("saturated: expected %b, got %b",
							head_answer.saturated, m_tuser[1]);
						error_count++;
					end
				end
			end
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
			$display("tb_shortest_path_distance: errors");
			$finish;
		end
	end

	initial begin
		spd_word_t w;
		int        pick;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		@(negedge clk);
		// empty graph: self query, then an unreachable pair
		push_query(0, 0);
		push_query(0, 15);
		push_load(0, 15, 255);
		push_load(0, 1, 1);
		push_load(1, 15, 1);
		push_load(15, 15, 8'h80);   // self-loop must not shorten anything
		push_query(0, 15);
		push_query(15, 15);
		push_query(15, 0);          // edges are directed
		push_load(1, 3, 1);
		push_load(0, 2, 1);
		push_load(2, 3, 1);
		push_query(0, 3);           // two equal paths
		push_load(1, 15, 0);        // weight 0 removes the edge
		push_query(0, 15);
		push_load(3, 15, 8'h7f);
		push_query(0, 15);
		push_load(15, 0, 8'h55);
		push_query(3, 1);
		push_load(15, 15, 0);
		push_query(15, 2);

		for (int phase = 0; phase < 4; phase++) begin
			@(negedge clk);
			send_idle_pct  = SEND_IDLE_PCT[phase];
			recv_stall_pct = RECV_STALL_PCT[phase];
			for (int n = 0; n < WORDS_PER_PHASE; n++) begin
				pick        = $urandom_range(99);
				w.operation = OP_LOAD;
				w.from_node = SPD_NODE_W'($urandom_range(NODES - 1));
				w.to_node   = SPD_NODE_W'($urandom_range(NODES - 1));
				w.weight    = SPD_WEIGHT_W'($urandom_range(255));
				if (pick < 45) begin
					w.operation = OP_QUERY;
					if (pick < 5) w.to_node = w.from_node;
				end else if (pick < 65) begin
					// light ring edges make long multi-hop paths win
					w.to_node = w.from_node + 1'b1;
					w.weight  = SPD_WEIGHT_W'($urandom_range(40, 1));
				end else if (pick < 85) begin
					w.weight = '0;
				end
				pending_words.push_back(w);
			end
			while (pending_words.size() != 0 || expected_answers.size() != 0)
				@(negedge clk);
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d edge writes and %0d queries, %0d of them unreachable,",
			load_count, query_count, unreach_count);
		$display("across no-idle, sender-idle, receiver-stall and mixed pacing");
		if (error_count == 0)
			$display("tb_shortest_path_distance: clean");
		else
			$display("tb_shortest_path_distance: errors");
		$finish;
	end

endmodule
